[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define CTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// An implication checked at every rising clock edge outside reset.
`define CTS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cts_pkg.sv]
// ----------------------------------------------------------------------------
// Task scheduler package
// Types, codes and constants shared by the scheduler modules.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int RESULT_LIMIT  = 16;

    localparam int TAG_W   = 8;
    localparam int DELAY_W = 32;
    localparam int RUNS_W  = 8;
    localparam int SLOT_W  = 4;

    localparam logic [RUNS_W-1:0] RUNS_MAX = '1;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_ADD      = 2'd1,
        KIND_DISPATCH = 2'd2,
        KIND_DELETE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_SLOT = 2'd2,
        ST_NONE_DUE = 2'd3
    } status_t;

    typedef enum logic {
        ALU_TICK = 1'b0,
        ALU_TAKE = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [DELAY_W-1:0] delay;
        logic [DELAY_W-1:0] period;
        logic [RUNS_W-1:0]  runs;
    } task_entry_t;

    typedef struct packed {
        logic has_runs;
        logic one_shot;
    } alu_flags_t;

endpackage

[hw/rtl/cts_store.sv]
// ----------------------------------------------------------------------------
// Task table store
// One write port and one registered read port over the packed task records.
// ----------------------------------------------------------------------------
module cts_store #(
    parameter int DEPTH = cts_pkg::MAX_TASKS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  cts_pkg::task_entry_t wr_data,
    input  logic [AW-1:0]       rd_addr,
    output cts_pkg::task_entry_t rd_data
);
    import cts_pkg::*;

    task_entry_t mem [DEPTH];
    task_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/cts_alu.sv]
// ----------------------------------------------------------------------------
// Task entry update unit
// Shared arithmetic for one table entry: tick countdown and run take-off.
// ----------------------------------------------------------------------------
module cts_alu (
    input  cts_pkg::alu_op_t    op,
    input  cts_pkg::task_entry_t entry_in,
    output cts_pkg::task_entry_t entry_out,
    output cts_pkg::alu_flags_t  flags
);
    import cts_pkg::*;

    always_comb
    begin
        entry_out      = entry_in;
        flags.has_runs = (entry_in.runs != '0);
        flags.one_shot = (entry_in.period == '0);
        case (op)
            ALU_TICK:
            begin
                if (entry_in.delay != '0)
                begin
                    entry_out.delay = entry_in.delay - DELAY_W'(1);
                end
                else
                begin
                    // Reload from the period; the run count sticks at its maximum.
                    entry_out.delay = entry_in.period;
                    if (entry_in.runs != RUNS_MAX)
                    begin
                        entry_out.runs = entry_in.runs + RUNS_W'(1);
                    end
                end
            end
            ALU_TAKE:
            begin
                entry_out.runs = entry_in.runs - RUNS_W'(1);
            end
            default:
            begin
                entry_out = entry_in;
            end
        endcase
    end

endmodule

[hw/rtl/cooperative_task_scheduler.sv]
// ----------------------------------------------------------------------------
// Cooperative task scheduler
// One item at a time: the single read port of the task table, with registered
// read data, is walked one entry at a time by the sequencer.
// Reset empties the table at once; the table memory itself is never cleared.
// ----------------------------------------------------------------------------
module cooperative_task_scheduler #(
    parameter int MAX_TASKS = cts_pkg::MAX_TASKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   kind,
    input  logic [cts_pkg::TAG_W-1:0]    task_tag,
    input  logic [cts_pkg::DELAY_W-1:0]  first_delay,
    input  logic [cts_pkg::DELAY_W-1:0]  repeat_period,
    input  logic [cts_pkg::SLOT_W-1:0]   slot,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cts_pkg::TAG_W-1:0]    run_tag,
    output logic [cts_pkg::SLOT_W-1:0]   run_slot,
    output logic                         removed,
    output logic [1:0]                   status,
    output logic                         last
);
    import cts_pkg::*;

    localparam int AW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW   = $clog2(MAX_TASKS + 1);
    localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int NW   = $clog2(RESULT_LIMIT + 1);

    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_TASKS);
    localparam logic [NW-1:0] N_LIMIT   = NW'(RESULT_LIMIT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_D_RD,
        S_D_EX,
        S_SH_RD,
        S_SH_WR,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       sh_reg, sh_next;
    logic [NW-1:0]       n_reg, n_next;
    logic                from_dispatch_reg, from_dispatch_next;

    logic                hold_valid_reg, hold_valid_next;
    logic [TAG_W-1:0]    hold_tag_reg, hold_tag_next;
    logic [SLOT_W-1:0]   hold_slot_reg, hold_slot_next;
    logic                hold_removed_reg, hold_removed_next;
    status_t             hold_status_reg, hold_status_next;

    logic                out_valid_reg, out_valid_next;
    logic [TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_removed_reg, out_removed_next;
    status_t             out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic                can_load;
    logic [CW-1:0]       idx_prev;
    logic [CW-1:0]       sh_inc;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    task_entry_t         mem_wdata;
    task_entry_t         mem_rdata;
    task_entry_t         new_entry;
    task_entry_t         alu_entry;
    alu_op_t             alu_op;
    alu_flags_t          alu_flags;

    cts_store #(
        .DEPTH (MAX_TASKS)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    cts_alu u_alu (
        .op        (alu_op),
        .entry_in  (mem_rdata),
        .entry_out (alu_entry),
        .flags     (alu_flags)
    );

    assign can_load = !out_valid_reg || out_ready;
    assign idx_prev = idx_reg - CW'(1);
    assign sh_inc   = sh_reg + CW'(1);

    always_comb
    begin
        new_entry.tag    = task_tag;
        new_entry.delay  = first_delay;
        new_entry.period = repeat_period;
        new_entry.runs   = '0;
    end

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        idx_next           = idx_reg;
        sh_next            = sh_reg;
        n_next             = n_reg;
        from_dispatch_next = from_dispatch_reg;
        hold_valid_next    = hold_valid_reg;
        hold_tag_next      = hold_tag_reg;
        hold_slot_next     = hold_slot_reg;
        hold_removed_next  = hold_removed_reg;
        hold_status_next   = hold_status_reg;
        out_valid_next     = out_valid_reg;
        out_tag_next       = out_tag_reg;
        out_slot_next      = out_slot_reg;
        out_removed_next   = out_removed_reg;
        out_status_next    = out_status_reg;
        out_last_next      = out_last_reg;
        mem_we             = 1'b0;
        mem_waddr          = idx_reg[AW-1:0];
        mem_wdata          = alu_entry;
        mem_raddr          = idx_reg[AW-1:0];
        alu_op             = ALU_TAKE;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    hold_valid_next    = 1'b1;
                    hold_tag_next      = '0;
                    hold_slot_next     = '0;
                    hold_removed_next  = 1'b0;
                    hold_status_next   = ST_OK;
                    from_dispatch_next = 1'b0;
                    n_next             = '0;
                    idx_next           = '0;
                    case (kind)
                        KIND_TICK:
                        begin
                            state_next = S_TICK;
                        end
                        KIND_ADD:
                        begin
                            if (count_reg < COUNT_MAX)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = new_entry;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                hold_status_next = ST_FULL;
                            end
                            state_next = S_FINISH;
                        end
                        KIND_DISPATCH:
                        begin
                            hold_valid_next    = 1'b0;
                            from_dispatch_next = 1'b1;
                            state_next         = S_D_RD;
                        end
                        KIND_DELETE:
                        begin
                            if (CMPW'(slot) < CMPW'(count_reg))
                            begin
                                sh_next    = CW'(slot);
                                state_next = S_SH_RD;
                            end
                            else
                            begin
                                hold_status_next = ST_BAD_SLOT;
                                state_next       = S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            // Read entry idx while writing back entry idx - 1, read in the cycle before.
            S_TICK:
            begin
                alu_op = ALU_TICK;
                if (idx_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_prev[AW-1:0];
                end
                if (idx_reg == count_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_D_RD:
            begin
                if (idx_reg >= count_reg || n_reg == N_LIMIT)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_D_EX;
                end
            end

            // A result is held back until the next one appears, so that the
            // final transaction of a dispatch can be marked as the last.
            S_D_EX:
            begin
                if (!alu_flags.has_runs)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_D_RD;
                end
                else if (!hold_valid_reg || can_load)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next   = 1'b1;
                        out_tag_next     = hold_tag_reg;
                        out_slot_next    = hold_slot_reg;
                        out_removed_next = hold_removed_reg;
                        out_status_next  = hold_status_reg;
                        out_last_next    = 1'b0;
                    end
                    hold_valid_next   = 1'b1;
                    hold_tag_next     = mem_rdata.tag;
                    hold_slot_next    = SLOT_W'(idx_reg);
                    hold_removed_next = alu_flags.one_shot;
                    hold_status_next  = ST_OK;
                    n_next            = n_reg + NW'(1);
                    if (alu_flags.one_shot)
                    begin
                        sh_next    = idx_reg;
                        state_next = S_SH_RD;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_D_RD;
                    end
                end
            end

            S_SH_RD:
            begin
                mem_raddr = sh_inc[AW-1:0];
                if (sh_inc >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = from_dispatch_reg ? S_D_RD : S_FINISH;
                end
                else
                begin
                    state_next = S_SH_WR;
                end
            end

            S_SH_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sh_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                sh_next    = sh_inc;
                state_next = S_SH_RD;
            end

            S_FINISH:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (hold_valid_reg)
                    begin
                        out_tag_next     = hold_tag_reg;
                        out_slot_next    = hold_slot_reg;
                        out_removed_next = hold_removed_reg;
                        out_status_next  = hold_status_reg;
                    end
                    else
                    begin
                        out_tag_next     = '0;
                        out_slot_next    = '0;
                        out_removed_next = 1'b0;
                        out_status_next  = ST_NONE_DUE;
                    end
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            idx_reg           <= '0;
            sh_reg            <= '0;
            n_reg             <= '0;
            from_dispatch_reg <= 1'b0;
            hold_valid_reg    <= 1'b0;
            hold_tag_reg      <= '0;
            hold_slot_reg     <= '0;
            hold_removed_reg  <= 1'b0;
            hold_status_reg   <= ST_OK;
            out_valid_reg     <= 1'b0;
            out_tag_reg       <= '0;
            out_slot_reg      <= '0;
            out_removed_reg   <= 1'b0;
            out_status_reg    <= ST_OK;
            out_last_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            idx_reg           <= idx_next;
            sh_reg            <= sh_next;
            n_reg             <= n_next;
            from_dispatch_reg <= from_dispatch_next;
            hold_valid_reg    <= hold_valid_next;
            hold_tag_reg      <= hold_tag_next;
            hold_slot_reg     <= hold_slot_next;
            hold_removed_reg  <= hold_removed_next;
            hold_status_reg   <= hold_status_next;
            out_valid_reg     <= out_valid_next;
            out_tag_reg       <= out_tag_next;
            out_slot_reg      <= out_slot_next;
            out_removed_reg   <= out_removed_next;
            out_status_reg    <= out_status_next;
            out_last_reg      <= out_last_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign run_tag   = out_tag_reg;
    assign run_slot  = out_slot_reg;
    assign removed   = out_removed_reg;
    assign status    = out_status_reg;
    assign last      = out_last_reg;

`include "assert_macros.svh"

    `CTS_ASSERT(a_count_bound, count_reg <= COUNT_MAX, "task count beyond table size")
    `CTS_ASSERT(a_result_bound, n_reg <= N_LIMIT, "dispatch result count beyond limit")
    `CTS_ASSERT_IMPL(a_hold_empty_on_accept, in_valid && in_ready, !hold_valid_reg,
                     "held result left over when a new transaction is accepted")
    `CTS_ASSERT_IMPL(a_shift_in_table, state_reg == S_SH_WR, sh_inc < count_reg,
                     "compaction step outside the occupied table")

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Task scheduler testbench
// Drives tick, add, dispatch and delete requests with random gaps and output
// stalls, mirrors the task table to predict every report, and compares each
// report field by field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;

    import cts_pkg::*;

    localparam int TABLE_SLOTS   = MAX_TASKS_DEF;
    localparam int RANDOM_ITEMS  = 40;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        logic [TAG_W-1:0]  tag;
        logic [SLOT_W-1:0] slot;
        logic              removed;
        status_t           status;
        logic              last;
    } sched_report_t;

    // Mirror of the task table; predicts the reports of each request.
    class sched_mirror;
        logic [TAG_W-1:0]   tags    [TABLE_SLOTS];
        logic [DELAY_W-1:0] delays  [TABLE_SLOTS];
        logic [DELAY_W-1:0] periods [TABLE_SLOTS];
        logic [RUNS_W-1:0]  runs    [TABLE_SLOTS];
        int unsigned        count;
        sched_report_t      due_reports[$];
        int unsigned        errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void post(logic [TAG_W-1:0] tag, logic [SLOT_W-1:0] pos, logic rem,
                           status_t st);
            sched_report_t rec;
            rec.tag     = tag;
            rec.slot    = pos;
            rec.removed = rem;
            rec.status  = st;
            rec.last    = 1'b0;
            due_reports.push_back(rec);
        endfunction

        function void drop_slot(int unsigned pos);
            for (int unsigned j = pos; j + 1 < count; j++)
            begin
                tags[j]    = tags[j + 1];
                delays[j]  = delays[j + 1];
                periods[j] = periods[j + 1];
                runs[j]    = runs[j + 1];
            end
            count--;
        endfunction

        function void apply_request(kind_t k, logic [TAG_W-1:0] tag, logic [DELAY_W-1:0] dly,
                                    logic [DELAY_W-1:0] per, logic [SLOT_W-1:0] pos);
            int unsigned   i;
            int unsigned   n;
            logic          one_shot;
            sched_report_t rec;
            n = 0;
            case (k)
                KIND_TICK:
                begin
                    for (i = 0; i < count; i++)
                    begin
                        if (delays[i] != '0)
                            delays[i] = delays[i] - 1'b1;
                        else
                        begin
                            delays[i] = periods[i];
                            if (runs[i] != RUNS_MAX)
                                runs[i] = runs[i] + 1'b1;
                        end
                    end
                    post('0, '0, 1'b0, ST_OK);
                end
                KIND_ADD:
                begin
                    if (count < TABLE_SLOTS)
                    begin
                        tags[count]    = tag;
                        delays[count]  = dly;
                        periods[count] = per;
                        runs[count]    = '0;
                        count++;
                        post('0, '0, 1'b0, ST_OK);
                    end
                    else
                        post('0, '0, 1'b0, ST_FULL);
                end
                KIND_DISPATCH:
                begin
                    i = 0;
                    while (i < count && n < RESULT_LIMIT)
                    begin
                        if (runs[i] != '0)
                        begin
                            one_shot = (periods[i] == '0);
                            runs[i]  = runs[i] - 1'b1;
                            post(tags[i], SLOT_W'(i), one_shot, ST_OK);
                            n++;
                            // The entry that moves down into this position is looked at next.
                            if (one_shot)
                            begin
                                drop_slot(i);
                                continue;
                            end
                        end
                        i++;
                    end
                    if (n == 0)
                        post('0, '0, 1'b0, ST_NONE_DUE);
                end
                default:
                begin
                    if (pos < count)
                    begin
                        drop_slot(pos);
                        post('0, '0, 1'b0, ST_OK);
                    end
                    else
                        post('0, '0, 1'b0, ST_BAD_SLOT);
                end
            endcase
            rec      = due_reports.pop_back();
            rec.last = 1'b1;
            due_reports.push_back(rec);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic [TAG_W-1:0] tag, logic [SLOT_W-1:0] pos, logic rem,
                                   logic [1:0] st, logic lst);
            sched_report_t want;
            if (due_reports.size() == 0)
            begin
                $error("report with none outstanding: run_tag %0d status %0d", tag, st);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            compare_field("run_tag", want.tag, tag);
            compare_field("run_slot", 8'(want.slot), 8'(pos));
            compare_field("removed", 8'(want.removed), 8'(rem));
            compare_field("status", 8'(want.status), 8'(st));
            compare_field("last", 8'(want.last), 8'(lst));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           kind;
    logic [TAG_W-1:0]     task_tag;
    logic [DELAY_W-1:0]   first_delay;
    logic [DELAY_W-1:0]   repeat_period;
    logic [SLOT_W-1:0]    slot;
    logic                 out_valid;
    logic                 out_ready;
    logic [TAG_W-1:0]     run_tag;
    logic [SLOT_W-1:0]    run_slot;
    logic                 removed;
    logic [1:0]           status;
    logic                 last;

    sched_mirror mirror;
    int          send_calm;
    int          sink_calm;

    cooperative_task_scheduler i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .task_tag      (task_tag),
        .first_delay   (first_delay),
        .repeat_period (repeat_period),
        .slot          (slot),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .run_tag       (run_tag),
        .run_slot      (run_slot),
        .removed       (removed),
        .status        (status),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Mostly no gap or a short one, a few long ones, and now and then a calm stretch with none.
    function automatic int idle_cycles(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left = $urandom_range(20, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input kind_t k,
                                input logic [TAG_W-1:0] tag = '0,
                                input logic [DELAY_W-1:0] dly = '0,
                                input logic [DELAY_W-1:0] per = '0,
                                input logic [SLOT_W-1:0] pos = '0);
        int gap;
        gap = idle_cycles(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        task_tag      <= tag;
        first_delay   <= dly;
        repeat_period <= per;
        slot          <= pos;
        do
            @(posedge clk);
        while (!in_ready);
        mirror.apply_request(k, tag, dly, per, pos);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            mirror.check_report(run_tag, run_slot, removed, status, last);
    end

    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 8)
                repeat ($urandom_range(50, 200)) @(posedge clk);
            else
            begin
                repeat ($urandom_range(1, 8)) @(posedge clk);
                stall = idle_cycles(sink_calm);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        logic [TAG_W-1:0]   tag;
        logic [DELAY_W-1:0] dly;
        logic [DELAY_W-1:0] per;
        logic [SLOT_W-1:0]  pos;
        int                 pick;

        mirror        = new();
        send_calm     = 0;
        sink_calm     = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        kind          <= KIND_TICK;
        task_tag      <= '0;
        first_delay   <= '0;
        repeat_period <= '0;
        slot          <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: nothing due, bad slot, and a tick with nothing to count.
        send_request(KIND_DISPATCH);
        send_request(KIND_DELETE, '0, '0, '0, 4'd0);
        send_request(KIND_TICK);

        // Two one-shot tasks with a periodic one behind each, so that one dispatch
        // removes twice and must look at each entry that moves down.
        send_request(KIND_ADD, 8'hFF, 32'd0, 32'd0);
        send_request(KIND_ADD, 8'h00, 32'd1, 32'd1);
        send_request(KIND_ADD, 8'hA5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_ADD, 8'h5A, 32'd0, 32'd0);
        send_request(KIND_ADD, 8'h3C, 32'd0, 32'd2);
        send_request(KIND_TICK);
        send_request(KIND_TICK);
        send_request(KIND_DISPATCH);
        send_request(KIND_DISPATCH);
        send_request(KIND_DELETE, '0, '0, '0, 4'd15);
        send_request(KIND_DELETE, '0, '0, '0, 4'd1);
        send_request(KIND_DELETE, '0, '0, '0, 4'd1);
        send_request(KIND_TICK);

        // The 256th tick would carry the one-shot task's run count past its top.
        send_request(KIND_ADD, 8'h77, 32'd0, 32'd0);
        repeat (256) send_request(KIND_TICK);
        send_request(KIND_DISPATCH);
        send_request(KIND_DISPATCH);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            tag  = TAG_W'($urandom());
            dly  = $urandom();
            per  = $urandom();
            pos  = SLOT_W'($urandom());
            if (pick < 4)
            begin
                // Fill the table to the brim, then one add too many.
                while (mirror.count < TABLE_SLOTS)
                    send_request(KIND_ADD, TAG_W'($urandom()), $urandom_range(0, 3),
                                 $urandom_range(0, 2));
                send_request(KIND_ADD, tag, dly, per);
            end
            else if (pick < 32)
            begin
                case ($urandom_range(0, 9))
                    0: ;
                    1: dly = '1;
                    default: dly = $urandom_range(0, 4);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2: per = '0;
                    8: per = '1;
                    9: ;
                    default: per = $urandom_range(1, 5);
                endcase
                send_request(KIND_ADD, tag, dly, per, pos);
            end
            else if (pick < 64)
                send_request(KIND_TICK, tag, dly, per, pos);
            else if (pick < 84)
                send_request(KIND_DISPATCH, tag, dly, per, pos);
            else
            begin
                if (mirror.count > 0 && $urandom_range(0, 3) != 0)
                    pos = SLOT_W'($urandom_range(0, mirror.count - 1));
                send_request(KIND_DELETE, tag, dly, per, pos);
            end
        end
        in_valid <= 1'b0;

        while (mirror.due_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mirror.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/cts_pkg.sv
hw/rtl/cts_store.sv
hw/rtl/cts_alu.sv
hw/rtl/cooperative_task_scheduler.sv
dv/testbench.sv
